>>> src/gccc_pkg.sv
// Shared types and constants of the greedy coin change counter.
`default_nettype none

package gccc_pkg;

  localparam int FIELD_W = 16;
  localparam int COUNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COIN0 = 3'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_DIV,
    ST_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic pick_go;
    logic step;
    logic acc;
    logic emit;
  } ctrl_t;

endpackage

`default_nettype wire

>>> src/gccc_if.sv
// Handshake channel interfaces for query beats and result beats.
`default_nettype none

interface gccc_req_if
  import gccc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

interface gccc_rsp_if
  import gccc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] coin_total;
  logic [FIELD_W-1:0] unpaid_remainder;

  modport source (output valid, output coin_total, output unpaid_remainder, input ready);
  modport sink (input valid, input coin_total, input unpaid_remainder, output ready);
endinterface

`default_nettype wire

>>> src/greedy_coin_change_counter_core.sv
// Greedy coin change counter with one shared restoring divider.
//
//   Channel  Dir  Payload                        Beat taken when
//   req      in   amount                         req.valid && req.ready
//   rsp      out  coin_total, unpaid_remainder   rsp.valid && rsp.ready
//   cfg      in   cfg_index, cfg_data            cfg_write
//
// A query runs one division for each nonzero denomination that is tried before the
// remainder reaches zero (at most 6 denominations); the single divider retires one
// quotient bit per cycle, so each division steps through every bit of the amount.
// Reset is synchronous; it restores the register defaults and empties the result stage.
// A stalled result is held in the output register while the next query is worked on;
// that query waits in ST_FINISH, with req.ready low, until the register frees.
`default_nettype none

module greedy_coin_change_counter_core
  import gccc_pkg::*;
#(
  parameter int MAX_COINS = 6,
  parameter int AMOUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [FIELD_W-1:0]   cfg_data,
  gccc_req_if.sink                  req,
  gccc_rsp_if.source                rsp
);

  localparam int W = AMOUNT_BITS;
  localparam int IW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CNT_W = $clog2(AMOUNT_BITS);
  localparam int SUM_W = ((AMOUNT_BITS > FIELD_W) ? AMOUNT_BITS : FIELD_W) + 1;

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [COUNT_W-1:0] coin_count;
  logic [FIELD_W-1:0] coins [MAX_COINS];
  logic [COUNT_W-1:0] used;

  logic [MAX_COINS-1:0] taken;
  logic [W-1:0]         rem;
  logic [FIELD_W-1:0]   total;
  logic [FIELD_W-1:0]   divisor;
  logic [W-1:0]         quo;
  logic [FIELD_W-1:0]   part;
  logic [CNT_W-1:0]     cnt;

  logic [IW-1:0]      best_idx;
  logic [FIELD_W-1:0] best_val;
  logic               proceed;
  logic               div_last;

  logic [FIELD_W:0]   trial;
  logic [FIELD_W:0]   diff;
  logic               fits;
  logic [FIELD_W-1:0] part_next;
  logic [W-1:0]       quo_next;
  logic [SUM_W-1:0]   sum;
  logic [FIELD_W-1:0] total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_count <= COUNT_W'(1);
      for (int i = 0; i < MAX_COINS; i++) begin
        coins[i] <= (i == 0) ? FIELD_W'(1) : '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == CFG_IDX_COUNT) begin
        coin_count <= cfg_data[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_COINS; i++) begin
        if (cfg_index == CFG_IDX_COIN0 + CFG_IDX_W'(i)) begin
          coins[i] <= cfg_data;
        end
      end
    end
  end

  assign used = (coin_count > COUNT_W'(MAX_COINS)) ? COUNT_W'(MAX_COINS) : coin_count;

  always_comb begin
    best_idx = '0;
    best_val = '0;
    for (int i = 0; i < MAX_COINS; i++) begin
      if ((COUNT_W'(i) < used) && !taken[i] && (coins[i] > best_val)) begin
        best_idx = IW'(i);
        best_val = coins[i];
      end
    end
  end

  assign proceed = (rem != '0) && (best_val != '0);
  assign div_last = (cnt == CNT_W'(AMOUNT_BITS - 1));

  assign trial = {part, quo[W-1]};
  assign diff = trial - {1'b0, divisor};
  assign fits = !diff[FIELD_W];
  assign part_next = fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
  assign quo_next = {quo[W-2:0], fits};

  assign sum = SUM_W'(total) + SUM_W'(quo);
  assign total_next = (sum > SUM_W'(FIELD_MAX)) ? FIELD_MAX : sum[FIELD_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        state_next = proceed ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = ST_PICK;
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    req.ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ctrl.load = req.valid;
      end
      ST_PICK: begin
        ctrl.pick_go = proceed;
      end
      ST_DIV: begin
        ctrl.step = 1'b1;
      end
      ST_ACC: begin
        ctrl.acc = 1'b1;
      end
      ST_FINISH: begin
        ctrl.emit = !rsp.valid || rsp.ready;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= W'(req.amount);
      total <= '0;
      taken <= '0;
    end
    if (ctrl.pick_go) begin
      taken[best_idx] <= 1'b1;
      divisor <= best_val;
      quo <= rem;
      part <= '0;
      cnt <= '0;
    end
    if (ctrl.step) begin
      quo <= quo_next;
      part <= part_next;
      cnt <= cnt + CNT_W'(1);
    end
    if (ctrl.acc) begin
      total <= total_next;
      rem <= W'(part);
    end
    if (ctrl.emit) begin
      rsp.coin_total <= total;
      rsp.unpaid_remainder <= FIELD_W'(rem);
    end
  end

endmodule

`default_nettype wire

>>> src/gccc_check.sv
// Port-level checker for the greedy coin change counter and its bind.
`default_nettype none

module gccc_check
  import gccc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [FIELD_W-1:0] rsp_coin_total,
  input wire logic [FIELD_W-1:0] rsp_unpaid_remainder
);

  logic [1:0] pend;
  logic [1:0] pend_next;
  logic       req_beat;
  logic       rsp_beat;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  always_comb begin
    pend_next = pend;
    if (req_beat && !rsp_beat) begin
      pend_next = pend + 2'd1;
    end else if (rsp_beat && !req_beat) begin
      pend_next = pend - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // A result beat always answers an earlier query beat.
  a_rsp_has_query: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pend != 2'd0))
    else $error("result shown without an outstanding query");

  // At most one query is worked on while one result waits.
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("too many queries outstanding");

  // The block holds off new queries while one is in work.
  a_busy_after_query: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> !req_ready)
    else $error("query accepted while busy");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coin_total)
      && $stable(rsp_unpaid_remainder))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind greedy_coin_change_counter_core gccc_check u_gccc_check (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_coin_total       (rsp.coin_total),
  .rsp_unpaid_remainder (rsp.unpaid_remainder)
);

`default_nettype wire
